/* rtl/qsu_pkg.sv */
// ============================================================================
// qsu_pkg
// Types and constants shared by the quoted string unescaper.
// ============================================================================
`default_nettype none

package qsu_pkg;

    typedef enum logic [2:0] {
        PH_OPEN = 3'd0,
        PH_TEXT = 3'd1,
        PH_ESC  = 3'd2,
        PH_HEX1 = 3'd3,
        PH_HEX2 = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_UNKNOWN   = 2'd1,
        ERR_BAD_HEX   = 2'd2,
        ERR_TRUNCATED = 2'd3
    } err_t;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NUL    = 8'h00;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       token_end;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       string_done;
        logic [1:0] error_code;
    } out_item_t;

    typedef struct packed {
        logic ok;
        logic [3:0] nibble;
    } hex_t;

    // Hex digit decode: 0-9, a-f and A-F.
    function automatic hex_t hex_value(input logic [7:0] c);
        hex_t h;
        h.ok     = 1'b1;
        h.nibble = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            h.nibble = c[3:0];
        end
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
        begin
            h.nibble = c[3:0] + 4'd9;
        end
        else
        begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

`default_nettype wire

/* rtl/qsu_ifs.sv */
// ============================================================================
// qsu_ifs
// Stream channels of the quoted string unescaper: raw bytes in, results out.
// ============================================================================
`default_nettype none

interface qsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       token_end;

    modport source (output valid, output in_byte, output token_end, input ready);
    modport sink   (input valid, input in_byte, input token_end, output ready);
endinterface

interface qsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       string_done;
    logic [1:0] error_code;

    modport source (output valid, output out_byte, output byte_valid,
                    output string_done, output error_code, input ready);
    modport sink   (input valid, input out_byte, input byte_valid,
                    input string_done, input error_code, output ready);
endinterface

`default_nettype wire

/* rtl/quoted_string_unescaper.sv */
// ============================================================================
// quoted_string_unescaper
// Decodes the bytes of a C-style quoted string token, one byte per cycle while the output does not stall.
//
//   channel     dir  handshake     payload
//   in_stream   in   valid/ready   in_byte[7:0], token_end
//   out_stream  out  valid/ready   out_byte[7:0], byte_valid, string_done,
//                                  error_code[1:0]
//
// One byte is taken per cycle while the output does not hold the flow; a byte
// passes the input register, the decode logic and the result register, and its
// result is offered on the output once it is in the result register.
// The state update of the decoder sets the rate.
// Bytes that yield no result (opening quote, backslash, the x and first digit
// of a hex escape, discarded bytes) never wait on the output side. Reset clears
// the decoder state to "expecting opening quote" and empties both registers.
// ============================================================================
`default_nettype none

module quoted_string_unescaper (
    input  wire logic  clk,
    input  wire logic  rst_n,
    qsu_in_if.sink     in_stream,
    qsu_out_if.source  out_stream
);
    import qsu_pkg::*;

    logic      item_valid;
    in_item_t  item;
    logic      has_result;
    out_item_t result;
    logic      out_free;
    logic      advance;

    // A byte is decoded once any result it makes has a place to go.
    assign advance = item_valid && (!has_result || out_free);

    qsu_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_stream  (in_stream),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    qsu_decode u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .item       (item),
        .has_result (has_result),
        .result     (result)
    );

    qsu_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .out_stream (out_stream),
        .load       (advance && has_result),
        .result     (result),
        .free       (out_free)
    );

endmodule

`default_nettype wire

/* rtl/qsu_in_stage.sv */
// ============================================================================
// qsu_in_stage
// Input register: captures one raw byte and holds it until it is decoded.
// ============================================================================
`default_nettype none

module qsu_in_stage (
    input  wire logic              clk,
    input  wire logic              rst_n,
    qsu_in_if.sink                 in_stream,
    input  wire logic              advance,
    output logic                   item_valid,
    output qsu_pkg::in_item_t      item
);
    import qsu_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;
    logic     take;

    // The register frees up in the same cycle in which its item is decoded.
    assign in_stream.ready = !valid_reg || advance;
    assign take            = in_stream.valid && in_stream.ready;
    assign valid_next      = take || (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.in_byte   <= in_stream.in_byte;
            item_reg.token_end <= in_stream.token_end;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

/* rtl/qsu_decode.sv */
// ============================================================================
// qsu_decode
// Escape decoder: phase, hex nibble and discard state, updated per byte.
// ============================================================================
`default_nettype none

module qsu_decode (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               advance,
    input  wire qsu_pkg::in_item_t  item,
    output logic                    has_result,
    output qsu_pkg::out_item_t      result
);
    import qsu_pkg::*;

    phase_t     phase_reg;
    phase_t     phase_next;
    logic [3:0] high_nibble_reg;
    logic [3:0] high_nibble_next;
    logic       discarding_reg;
    logic       discarding_next;
    hex_t       hex;

    assign hex = hex_value(item.in_byte);

    always_comb
    begin
        phase_next       = phase_reg;
        high_nibble_next = high_nibble_reg;
        discarding_next  = discarding_reg;
        has_result       = 1'b0;
        result           = '0;

        if (item.token_end)
        begin
            has_result         = 1'b1;
            result.string_done = 1'b1;
            if (!discarding_reg &&
                (phase_reg == PH_ESC || phase_reg == PH_HEX1 || phase_reg == PH_HEX2))
            begin
                result.error_code = ERR_TRUNCATED;
            end
            phase_next       = PH_OPEN;
            high_nibble_next = 4'd0;
            discarding_next  = 1'b0;
        end
        else
        begin
            case (phase_reg)
                PH_OPEN:
                begin
                    phase_next = PH_TEXT;
                end
                PH_ESC:
                begin
                    phase_next        = PH_TEXT;
                    has_result        = 1'b1;
                    result.byte_valid = 1'b1;
                    case (item.in_byte)
                        CH_N:      result.out_byte = CH_LF;
                        CH_T:      result.out_byte = CH_TAB;
                        CH_ZERO:   result.out_byte = CH_NUL;
                        CH_BSLASH: result.out_byte = CH_BSLASH;
                        CH_DQUOTE: result.out_byte = CH_DQUOTE;
                        CH_SQUOTE: result.out_byte = CH_SQUOTE;
                        CH_X:
                        begin
                            phase_next        = PH_HEX1;
                            has_result        = 1'b0;
                            result.byte_valid = 1'b0;
                        end
                        default:
                        begin
                            result.byte_valid = 1'b0;
                            result.error_code = ERR_UNKNOWN;
                            discarding_next   = 1'b1;
                        end
                    endcase
                end
                PH_HEX1:
                begin
                    if (hex.ok)
                    begin
                        high_nibble_next = hex.nibble;
                        phase_next       = PH_HEX2;
                    end
                    else
                    begin
                        phase_next        = PH_TEXT;
                        has_result        = 1'b1;
                        result.error_code = ERR_BAD_HEX;
                        discarding_next   = 1'b1;
                    end
                end
                PH_HEX2:
                begin
                    phase_next = PH_TEXT;
                    has_result = 1'b1;
                    if (hex.ok)
                    begin
                        result.out_byte   = {high_nibble_reg, hex.nibble};
                        result.byte_valid = 1'b1;
                    end
                    else
                    begin
                        result.error_code = ERR_BAD_HEX;
                        discarding_next   = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = PH_TEXT;
                    if (!discarding_reg)
                    begin
                        if (item.in_byte == CH_BSLASH)
                        begin
                            phase_next = PH_ESC;
                        end
                        else
                        begin
                            has_result        = 1'b1;
                            result.out_byte   = item.in_byte;
                            result.byte_valid = 1'b1;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_OPEN;
            high_nibble_reg <= 4'd0;
            discarding_reg  <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg       <= phase_next;
            high_nibble_reg <= high_nibble_next;
            discarding_reg  <= discarding_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/qsu_out_stage.sv */
// ============================================================================
// qsu_out_stage
// Result register: holds one decoded result until the consumer takes it.
// ============================================================================
`default_nettype none

module qsu_out_stage (
    input  wire logic                clk,
    input  wire logic                rst_n,
    qsu_out_if.source                out_stream,
    input  wire logic                load,
    input  wire qsu_pkg::out_item_t  result,
    output logic                     free
);
    import qsu_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    out_item_t result_reg;

    assign free       = !valid_reg || out_stream.ready;
    assign valid_next = load || (valid_reg && !out_stream.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign out_stream.valid       = valid_reg;
    assign out_stream.out_byte    = result_reg.out_byte;
    assign out_stream.byte_valid  = result_reg.byte_valid;
    assign out_stream.string_done = result_reg.string_done;
    assign out_stream.error_code  = result_reg.error_code;

endmodule

`default_nettype wire
